>>> rtl/rsfc_pkg.sv
package rsfc_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] word_t;
  typedef logic [15:0] half_t;
  typedef logic [4:0]  pos_t;

  // crc-32/mpeg-2 settings
  localparam word_t CrcInit   = 32'hFFFF_FFFF;
  localparam word_t CrcPoly   = 32'h04C1_1DB7;
  localparam word_t CrcTop    = 32'h8000_0000;
  localparam byte_t I2cPrefix = 8'hFA;

  // body lengths in bytes, the check word follows the body
  localparam pos_t ShortBody  = 5'd8;
  localparam pos_t LongBody   = 5'd20;
  localparam pos_t CheckBytes = 5'd4;

  // payload positions inside the body
  localparam pos_t FieldLo = 5'd4;
  localparam pos_t FieldHi = 5'd7;
  localparam pos_t AmpLo   = 5'd8;
  localparam pos_t AmpHi   = 5'd9;

  // one byte through the crc, msb first, eight unrolled shift steps
  function automatic word_t crc_feed(word_t crc, byte_t b);
    word_t c;
    c = crc ^ {b, 24'h000000};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcTop) != '0) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  // crc state after the implied i2c prefix byte
  localparam word_t CrcAfterPrefix = crc_feed(CrcInit, I2cPrefix);

endpackage

>>> rtl/rsfc_if.sv
// received byte channel
interface rsfc_in_if;
  import rsfc_pkg::*;
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  frame_start;
  logic  long_frame;
  modport source (output valid, data_byte, frame_start, long_frame, input ready);
  modport sink   (input valid, data_byte, frame_start, long_frame, output ready);
endinterface

// frame result channel
interface rsfc_out_if;
  import rsfc_pkg::*;
  logic  valid;
  logic  ready;
  logic  crc_ok;
  logic  was_long;
  word_t version_word;
  half_t distance_value;
  half_t amplitude_value;
  modport source (output valid, crc_ok, was_long, version_word, distance_value,
                  amplitude_value, input ready);
  modport sink   (input valid, crc_ok, was_long, version_word, distance_value,
                  amplitude_value, output ready);
endinterface

// configuration write channel
interface rsfc_cfg_if;
  logic valid;
  logic ready;
  logic bus_mode;
  modport source (output valid, bus_mode, input ready);
  modport sink   (input valid, bus_mode, output ready);
endinterface

>>> rtl/ranging_sensor_frame_checker.sv
// channel  | direction | beat contents
// ---------+-----------+------------------------------------------------------
// cfg      | in        | bus_mode (0 uart framing, 1 i2c with implied 0xFA)
// rx       | in        | data_byte, frame_start, long_frame
// res      | out       | crc_ok, was_long, version_word, distance_value,
//          |           | amplitude_value
//
// one byte per cycle while the result is not stalled: a byte is registered,
// then the byte-wide crc update and field capture feed the result register.
// a result is registered from the frame step on the last check byte.
// rst is synchronous, active high; it clears the pipeline, the frame and bus_mode.
// a stalled result holds the result register; rx keeps taking bytes while
// the registered byte can still move on.
module ranging_sensor_frame_checker (
  input logic        clk,
  input logic        rst,
  rsfc_cfg_if.sink   cfg,
  rsfc_in_if.sink    rx,
  rsfc_out_if.source res
);
  import rsfc_pkg::*;

  logic  bus_mode;

  // input register
  logic  s1_valid;
  byte_t s1_byte;
  logic  s1_start;
  logic  s1_long;

  // frame state
  word_t crc_reg;
  pos_t  byte_count;
  word_t check_word;
  word_t field_word;
  half_t amp_word;
  logic  kind_latch;
  logic  frame_active;

  // result register
  logic  out_valid;
  logic  out_crc_ok;
  logic  out_long;
  word_t out_version;
  half_t out_distance;
  half_t out_amplitude;

  // combinational step
  word_t crc_base;
  pos_t  pos;
  logic  kind;
  logic  active;
  pos_t  body;
  pos_t  diff;
  word_t crc_next;
  word_t check_next;
  word_t field_next;
  half_t amp_next;
  pos_t  byte_count_next;
  logic  done;
  logic  adv;

  // result register frees when empty or when its beat is taken
  assign adv      = !out_valid || res.ready;
  assign rx.ready = !s1_valid || adv;
  assign cfg.ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_mode <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      bus_mode <= cfg.bus_mode;
    end
  end

  // capture accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
    if (rx.valid && rx.ready) begin
      s1_byte  <= rx.data_byte;
      s1_start <= rx.frame_start;
      s1_long  <= rx.long_frame;
    end
  end

  // frame step: restart, crc update, field and check capture
  always_comb begin
    crc_base   = crc_reg;
    pos        = byte_count;
    kind       = kind_latch;
    active     = frame_active;
    check_next = check_word;
    field_next = field_word;
    amp_next   = amp_word;
    if (s1_start) begin
      kind       = s1_long;
      active     = 1'b1;
      check_next = '0;
      field_next = '0;
      amp_next   = '0;
      if (bus_mode) begin
        crc_base = CrcAfterPrefix;
        pos      = 5'd1;
      end else begin
        crc_base = CrcInit;
        pos      = '0;
      end
    end
    body     = kind ? LongBody : ShortBody;
    diff     = pos - body;
    crc_next = crc_base;
    if (pos < body) begin
      crc_next = crc_feed(crc_base, s1_byte);
      if (pos >= FieldLo && pos <= FieldHi) begin
        field_next[{pos[1:0], 3'b000} +: 8] = s1_byte;
      end else if (pos == AmpLo || pos == AmpHi) begin
        amp_next[{pos[0], 3'b000} +: 8] = s1_byte;
      end
    end else if (diff < CheckBytes) begin
      check_next[{diff[1:0], 3'b000} +: 8] = s1_byte;
    end
    done            = active && (pos >= body + CheckBytes - 5'd1);
    byte_count_next = pos + 5'd1;
  end

  // frame state update
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active <= 1'b0;
    end else if (s1_valid && adv) begin
      frame_active <= active && !done;
    end
    if (s1_valid && adv && active) begin
      crc_reg    <= crc_next;
      byte_count <= byte_count_next;
      check_word <= check_next;
      field_word <= field_next;
      amp_word   <= amp_next;
      kind_latch <= kind;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid && done;
    end
    if (adv && s1_valid && done) begin
      out_crc_ok    <= (crc_next == check_next);
      out_long      <= kind;
      out_version   <= kind ? '0 : field_next;
      out_distance  <= kind ? field_next[15:0] : '0;
      out_amplitude <= kind ? amp_next : '0;
    end
  end

  assign res.valid           = out_valid;
  assign res.crc_ok          = out_crc_ok;
  assign res.was_long        = out_long;
  assign res.version_word    = out_version;
  assign res.distance_value  = out_distance;
  assign res.amplitude_value = out_amplitude;

  // byte position never runs past the last check byte of a long frame
  assert property (@(posedge clk) disable iff (rst)
    frame_active |-> byte_count <= LongBody + CheckBytes - 5'd1)
    else $error("byte position beyond frame end");

  // a finished frame closes and raises its result
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && adv && done) |=> (!frame_active && out_valid))
    else $error("frame not closed after result");

  // rx stalls only while the registered byte is blocked
  assert property (@(posedge clk) disable iff (rst)
    !rx.ready |-> (s1_valid && out_valid && !res.ready))
    else $error("rx stalled without cause");

  // short results carry no measurement
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_long) |-> (out_distance == '0 && out_amplitude == '0))
    else $error("short frame result with measurement");

  // long results carry no version
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_long) |-> out_version == '0)
    else $error("long frame result with version");

endmodule
